@@ rtl/r2fft_pkg.sv @@
// shared types, widths and twiddle table for the radix-2 transform
`default_nettype none
package r2fft_pkg;

  localparam int SampleW = 16;
  localparam int BinW    = 19;
  localparam int TwW     = 17;
  localparam int ProdW   = TwW + BinW;
  localparam int ZW      = 23;
  localparam int WordW   = 2 * BinW;

  typedef logic signed [BinW-1:0]  bin_t;
  typedef logic signed [TwW-1:0]   tw_val_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [ZW-1:0]    z_t;

  typedef struct packed {
    tw_val_t c;
    tw_val_t s;
  } twiddle_t;

  // round(32768 * sin(2*pi*k/64)), k = 0..16
  function automatic tw_val_t sine_rom(input logic [4:0] k);
    tw_val_t v;
    case (k)
      5'd0:  v = 17'sd0;
      5'd1:  v = 17'sd3212;
      5'd2:  v = 17'sd6393;
      5'd3:  v = 17'sd9512;
      5'd4:  v = 17'sd12540;
      5'd5:  v = 17'sd15447;
      5'd6:  v = 17'sd18205;
      5'd7:  v = 17'sd20788;
      5'd8:  v = 17'sd23170;
      5'd9:  v = 17'sd25330;
      5'd10: v = 17'sd27246;
      5'd11: v = 17'sd28899;
      5'd12: v = 17'sd30274;
      5'd13: v = 17'sd31357;
      5'd14: v = 17'sd32138;
      5'd15: v = 17'sd32610;
      5'd16: v = 17'sd32768;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  // angle 2*pi*i/64 for i in 0..31
  function automatic twiddle_t twiddle(input logic [4:0] i);
    twiddle_t t;
    if (i <= 5'd16) begin
      t.c = sine_rom(5'd16 - i);
      t.s = sine_rom(i);
    end else begin
      t.c = -sine_rom(i - 5'd16);
      t.s = sine_rom(5'd0 - i);
    end
    return t;
  endfunction

  function automatic bin_t sat_bin(input logic signed [ZW:0] x);
    bin_t r;
    if (x > (ZW+1)'(262143)) begin
      r = 19'sh3ffff;
    end else if (x < -(ZW+1)'(262144)) begin
      r = 19'sh40000;
    end else begin
      r = x[BinW-1:0];
    end
    return r;
  endfunction

  // (x + 1) >> 1 arithmetic
  function automatic bin_t half_round(input bin_t x);
    logic signed [BinW:0] t;
    t = (BinW+1)'(x) + (BinW+1)'(1);
    return t[BinW:1];
  endfunction

endpackage
`default_nettype wire

@@ rtl/r2fft_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module r2fft_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/radix2_complex_fft_ifft.sv @@
// top level: radix-2 decimation-in-time fft / ifft over one work ram
//
// channel   dir  fields (low bit first)                       request when
// s_axis    in   tdata: sample_re[15:0], sample_im[31:16]      tvalid & tready
//                tlast: sample_last
// m_axis    out  tdata: bin_re[18:0], bin_im[37:19], 0 pad    tvalid & tready
//                tlast: bin_last
// cfg       in   cfg_wdata: inverse_mode                      cfg_wen
//
// load writes samples at bit-reversed addresses; a short block is zero filled
// butterfly: rda, rdb, capb, 4 products on shared multiplier, rnd, wra, wrb
// unload reads the ram once per bin and waits while the output is stalled
// rst clears control state; ram contents are not cleared
`default_nettype none
module radix2_complex_fft_ifft #(
  parameter int POINTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // sample_re, sample_im
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,  // bin_re, bin_im, zero pad
  output logic             m_axis_tlast,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata
);

  localparam int AW = $clog2(POINTS);
  localparam int SW = (AW > 1) ? $clog2(AW) : 1;
  localparam int BW = r2fft_pkg::BinW;

  typedef enum logic [9:0] {
    ST_LOAD   = 10'b0000000001,
    ST_FILL   = 10'b0000000010,
    ST_RDA    = 10'b0000000100,
    ST_RDB    = 10'b0000001000,
    ST_CAPB   = 10'b0000010000,
    ST_MUL    = 10'b0000100000,
    ST_RND    = 10'b0001000000,
    ST_WRA    = 10'b0010000000,
    ST_WRB    = 10'b0100000000,
    ST_UNLOAD = 10'b1000000000
  } state_t;

  state_t state;
  logic inverse_mode;
  logic [AW-1:0] cnt;
  logic [AW-1:0] j;
  logic [SW-1:0] st;
  logic [1:0] mstep;
  logic [AW-1:0] ucnt;
  logic rd_pend;
  logic pend_last;

  r2fft_pkg::bin_t a_re, a_im, b_re, b_im;
  r2fft_pkg::prod_t p0, p1, p2, p3;
  r2fft_pkg::z_t zr, zi;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [r2fft_pkg::WordW-1:0] wdata, rdata;

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) begin
      r[b] = x[AW-1-b];
    end
    return r;
  endfunction

  // butterfly addressing, twiddle and arithmetic
  logic [AW-1:0] mask, jm, ia, ib;
  logic [AW:0] base;
  logic [5:0] tw_sh;
  r2fft_pkg::twiddle_t tw;
  r2fft_pkg::tw_val_t s_eff, mul_x;
  r2fft_pkg::bin_t mul_y;
  r2fft_pkg::prod_t prod;
  logic signed [r2fft_pkg::ProdW+1:0] zr_full, zi_full;
  logic signed [r2fft_pkg::ZW:0] sum_re, sum_im, dif_re, dif_im;
  logic in_req;

  always_comb begin
    mask  = ~({AW{1'b1}} << st);
    jm    = j & mask;
    base  = ({1'b0, j} >> st) << (st + SW'(1));
    ia    = base[AW-1:0] | jm;
    ib    = ia | (AW'(1) << st);
    tw_sh = 6'(jm) << (3'd5 - 3'(st));
    tw    = r2fft_pkg::twiddle(tw_sh[4:0]);
    s_eff = inverse_mode ? tw.s : -tw.s;
    mul_x = (mstep == 2'd0 || mstep == 2'd2) ? tw.c : s_eff;
    mul_y = (mstep == 2'd0 || mstep == 2'd3) ? b_re : b_im;
    prod  = r2fft_pkg::ProdW'(mul_x) * r2fft_pkg::ProdW'(mul_y);
    zr_full = (r2fft_pkg::ProdW+2)'(p0) - (r2fft_pkg::ProdW+2)'(p1)
              + (r2fft_pkg::ProdW+2)'(16384);
    zi_full = (r2fft_pkg::ProdW+2)'(p2) + (r2fft_pkg::ProdW+2)'(p3)
              + (r2fft_pkg::ProdW+2)'(16384);
    sum_re = (r2fft_pkg::ZW+1)'(a_re) + (r2fft_pkg::ZW+1)'(zr);
    sum_im = (r2fft_pkg::ZW+1)'(a_im) + (r2fft_pkg::ZW+1)'(zi);
    dif_re = (r2fft_pkg::ZW+1)'(a_re) - (r2fft_pkg::ZW+1)'(zr);
    dif_im = (r2fft_pkg::ZW+1)'(a_im) - (r2fft_pkg::ZW+1)'(zi);
  end

  assign s_axis_tready = (state == ST_LOAD);
  assign in_req = s_axis_tvalid && s_axis_tready;

  // ram port selection
  always_comb begin
    we    = 1'b0;
    waddr = bitrev(cnt);
    wdata = '0;
    raddr = ucnt;
    case (state)
      ST_LOAD: begin
        we    = in_req;
        wdata = {BW'(signed'(s_axis_tdata[31:16])), BW'(signed'(s_axis_tdata[15:0]))};
      end
      ST_FILL: begin
        we = 1'b1;
      end
      ST_RDA: begin
        raddr = ia;
      end
      ST_RDB: begin
        raddr = ib;
      end
      ST_WRA: begin
        we    = 1'b1;
        waddr = ia;
        wdata = {r2fft_pkg::sat_bin(sum_im), r2fft_pkg::sat_bin(sum_re)};
      end
      ST_WRB: begin
        we    = 1'b1;
        waddr = ib;
        wdata = {r2fft_pkg::sat_bin(dif_im), r2fft_pkg::sat_bin(dif_re)};
      end
      default: begin
      end
    endcase
  end

  r2fft_ram #(
    .WIDTH (r2fft_pkg::WordW),
    .DEPTH (POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (cfg_wen) begin
      inverse_mode <= cfg_wdata;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_RDB: begin
        a_re <= inverse_mode ? r2fft_pkg::half_round(rdata[BW-1:0]) : rdata[BW-1:0];
        a_im <= inverse_mode ? r2fft_pkg::half_round(rdata[2*BW-1:BW])
                             : rdata[2*BW-1:BW];
      end
      ST_CAPB: begin
        b_re <= inverse_mode ? r2fft_pkg::half_round(rdata[BW-1:0]) : rdata[BW-1:0];
        b_im <= inverse_mode ? r2fft_pkg::half_round(rdata[2*BW-1:BW])
                             : rdata[2*BW-1:BW];
      end
      ST_MUL: begin
        case (mstep)
          2'd0: p0 <= prod;
          2'd1: p1 <= prod;
          2'd2: p2 <= prod;
          default: p3 <= prod;
        endcase
      end
      ST_RND: begin
        zr <= zr_full[r2fft_pkg::ZW+14:15];
        zi <= zi_full[r2fft_pkg::ZW+14:15];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      cnt           <= '0;
      j             <= '0;
      st            <= '0;
      mstep         <= '0;
      ucnt          <= '0;
      rd_pend       <= 1'b0;
      pend_last     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_req) begin
            if (cnt == AW'(POINTS - 1)) begin
              cnt   <= '0;
              state <= ST_RDA;
            end else begin
              cnt <= cnt + AW'(1);
              if (s_axis_tlast) begin
                state <= ST_FILL;
              end
            end
          end
        end
        ST_FILL: begin
          if (cnt == AW'(POINTS - 1)) begin
            cnt   <= '0;
            state <= ST_RDA;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_RDA:  state <= ST_RDB;
        ST_RDB:  state <= ST_CAPB;
        ST_CAPB: begin
          mstep <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) begin
            state <= ST_RND;
          end
        end
        ST_RND: state <= ST_WRA;
        ST_WRA: state <= ST_WRB;
        ST_WRB: begin
          if (j == AW'(POINTS / 2 - 1)) begin
            j <= '0;
            if (st == SW'(AW - 1)) begin
              st        <= '0;
              ucnt      <= '0;
              rd_pend   <= 1'b0;
              pend_last <= 1'b0;
              state     <= ST_UNLOAD;
            end else begin
              st    <= st + SW'(1);
              state <= ST_RDA;
            end
          end else begin
            j     <= j + AW'(1);
            state <= ST_RDA;
          end
        end
        ST_UNLOAD: begin
          if (rd_pend) begin
            // output register is known free here
            rd_pend       <= 1'b0;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, rdata};
            m_axis_tlast  <= pend_last;
            if (pend_last) begin
              state <= ST_LOAD;
            end
          end else if (!m_axis_tvalid || m_axis_tready) begin
            rd_pend   <= 1'b1;
            pend_last <= (ucnt == AW'(POINTS - 1));
            ucnt      <= ucnt + AW'(1);
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register lost its one-hot code");

  a_no_write_unload: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UNLOAD || state == ST_RDA || state == ST_RDB) |-> !we)
    else $error("ram written while reading back results");

  a_pend_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UNLOAD && rd_pend) |=> m_axis_tvalid)
    else $error("pending bin read not presented");

  a_fill_after_sample: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cnt != '0))
    else $error("zero fill started with no sample loaded");

endmodule
`default_nettype wire
